@@ rtl/sgs_pkg.sv @@
// Shared types and constants for the silence gap segmenter.
// Used by sgs_regs, silence_gap_segmenter_top and tb_top; it depends on nothing else.
`default_nettype none

package sgs_pkg;

	// Width of the internal byte position and length arithmetic.
	localparam int POS_W = 32;
	// Width of the position and length result fields.
	localparam int OUT_W = 32;
	// Width used to compare a segment length against the minimum length.
	localparam int CMP_W = (POS_W > OUT_W) ? POS_W : OUT_W;

	// Configuration port geometry.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register reset values.
	localparam logic [7:0]  SENSITIVITY_RST     = 8'd3;
	localparam logic [15:0] SILENCE_RUN_RST     = 16'd500;
	localparam logic [31:0] MIN_LENGTH_RST      = 32'd8000;
	localparam logic [3:0]  BYTES_PER_FRAME_RST = 4'd2;

	typedef logic [POS_W-1:0] pos_t;

	// Register indexes, one word apart on the configuration port.
	typedef enum logic [1:0] {
		REG_SENSITIVITY,
		REG_SILENCE_RUN,
		REG_MIN_LENGTH,
		REG_BYTES_PER_FRAME
	} sgs_reg_t;

	// Effective configuration handed from the register file to the datapath.
	typedef struct packed {
		logic [7:0]  sensitivity;
		logic [15:0] run;        // silence run, zero already mapped to one
		logic [31:0] min_length;
		logic [3:0]  bpf;        // bytes per frame, zero already mapped to one
		pos_t        adjust;     // bpf minus run * bpf, modulo 2^POS_W
	} sgs_cfg_t;

endpackage

`default_nettype wire

@@ rtl/sgs_regs.sv @@
// Configuration register file of the silence gap segmenter with its APB-style port.
// Depends on sgs_pkg for the register indexes, reset values and the sgs_cfg_t struct.
`default_nettype none

module sgs_regs import sgs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output sgs_cfg_t               cfg
);

	logic [7:0]  sensitivity_q;
	logic [15:0] silence_run_q;
	logic [31:0] min_length_q;
	logic [3:0]  bytes_per_frame_q;
	pos_t        adjust_q;

	sgs_reg_t    reg_idx;
	logic        wr_en;
	logic [15:0] run_eff;
	logic [3:0]  bpf_eff;
	logic [19:0] back_bytes;

	assign reg_idx = sgs_reg_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;

	// Register writes complete in the access phase of a transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensitivity_q     <= SENSITIVITY_RST;
			silence_run_q     <= SILENCE_RUN_RST;
			min_length_q      <= MIN_LENGTH_RST;
			bytes_per_frame_q <= BYTES_PER_FRAME_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SENSITIVITY:     sensitivity_q     <= pwdata[7:0];
				REG_SILENCE_RUN:     silence_run_q     <= pwdata[15:0];
				REG_MIN_LENGTH:      min_length_q      <= pwdata[31:0];
				REG_BYTES_PER_FRAME: bytes_per_frame_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Read data is the raw register contents.
	always_comb begin
		case (reg_idx)
			REG_SENSITIVITY:     prdata = DATA_W'(sensitivity_q);
			REG_SILENCE_RUN:     prdata = DATA_W'(silence_run_q);
			REG_MIN_LENGTH:      prdata = DATA_W'(min_length_q);
			REG_BYTES_PER_FRAME: prdata = DATA_W'(bytes_per_frame_q);
			default:             prdata = '0;
		endcase
	end

	// A zero silence run or frame size behaves as one.
	assign run_eff    = (silence_run_q == 16'd0) ? 16'd1 : silence_run_q;
	assign bpf_eff    = (bytes_per_frame_q == 4'd0) ? 4'd1 : bytes_per_frame_q;
	assign back_bytes = 20'(run_eff) * 20'(bpf_eff);

	// Length correction for a segment closed by silence: one more frame,
	// minus the trailing silence run. Registered to keep the multiply
	// off the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adjust_q <= pos_t'(BYTES_PER_FRAME_RST)
				- pos_t'(20'(SILENCE_RUN_RST) * 20'(BYTES_PER_FRAME_RST));
		end else begin
			adjust_q <= pos_t'(bpf_eff) - pos_t'(back_bytes);
		end
	end

	assign cfg.sensitivity = sensitivity_q;
	assign cfg.run         = run_eff;
	assign cfg.min_length  = min_length_q;
	assign cfg.bpf         = bpf_eff;
	assign cfg.adjust      = adjust_q;

endmodule

`default_nettype wire

@@ rtl/silence_gap_segmenter_top.sv @@
// Top level of the silence gap segmenter: input register, segment tracking and result register.
// Depends on sgs_pkg and instantiates sgs_regs for the configuration port.
`default_nettype none

// The segmenter takes one audio frame per transaction (its deciding byte and an
// end-of-data flag) and reports each finished segment as one result transaction
// with its byte start, byte length, a kept flag against the minimum length and a
// flag telling whether end of data closed it. It accepts one frame in every clock
// cycle while the result register is free or being read out; a frame's result, when
// it has one, passes from an input register through the segment logic into a result
// register. in_ready follows out_ready combinationally when both registers hold
// data. After the frame marked end of data, further frames are taken and dropped
// until reset. Write the configuration registers only while no frame is in flight.

module silence_gap_segmenter_top import sgs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration port.
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	// Frame input.
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        sample_byte,
	input  wire logic              end_of_data,
	// Segment output.
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [OUT_W-1:0]  segment_start,
	output logic      [OUT_W-1:0]  segment_length,
	output logic                   segment_kept,
	output logic                   final_segment
);

	sgs_cfg_t cfg;

	// Input register.
	logic       valid_s1;
	logic [7:0] sample_s1;
	logic       eod_s1;

	// Segment state.
	logic [7:0]  prev_q;
	logic        active_q;
	logic [15:0] quiet_cnt_q;
	pos_t        pos_q;
	pos_t        begin_q;
	pos_t        seg_len_q;
	logic        finished_q;

	// Result register.
	logic             out_valid_q;
	logic [OUT_W-1:0] start_q;
	logic [OUT_W-1:0] length_q;
	logic             kept_q;
	logic             final_q;

	logic        advance;
	logic [7:0]  diff;
	logic        quiet;
	pos_t        bpf_pos;
	pos_t        pos_next;
	pos_t        len_grow;
	pos_t        len_close;
	logic [15:0] quiet_inc;

	logic        active_n;
	logic [15:0] quiet_cnt_n;
	pos_t        begin_n;
	pos_t        seg_len_n;
	logic        emit;
	logic        emit_final;
	pos_t        emit_len;

	sgs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// The frame in the input register moves on when the result register is free or is being read out.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample_byte;
			eod_s1    <= end_of_data;
		end
	end

	// Quiet detection against the previous frame's byte.
	assign diff  = (sample_s1 > prev_q) ? (sample_s1 - prev_q) : (prev_q - sample_s1);
	assign quiet = diff < cfg.sensitivity;

	// Position and running segment length for this frame.
	assign bpf_pos   = pos_t'(cfg.bpf);
	assign pos_next  = pos_q + bpf_pos;
	assign len_grow  = seg_len_q + bpf_pos;
	assign len_close = seg_len_q + cfg.adjust;

	// The quiet counter saturates rather than wrapping.
	assign quiet_inc = !quiet ? 16'd0 : ((quiet_cnt_q == 16'hFFFF) ? quiet_cnt_q
		: quiet_cnt_q + 16'd1);

	// Segment open and close decisions.
	always_comb begin
		active_n    = active_q;
		quiet_cnt_n = quiet_cnt_q;
		begin_n     = begin_q;
		seg_len_n   = seg_len_q;
		emit        = 1'b0;
		emit_final  = 1'b0;
		emit_len    = len_close;
		if (!active_q) begin
			if (!quiet) begin
				active_n    = 1'b1;
				begin_n     = pos_q;
				quiet_cnt_n = 16'd0;
				seg_len_n   = bpf_pos;
			end
		end else begin
			quiet_cnt_n = quiet_inc;
			seg_len_n   = len_grow;
			if (quiet_inc >= cfg.run) begin
				emit        = 1'b1;
				active_n    = 1'b0;
				quiet_cnt_n = 16'd0;
			end
		end
		// End of data closes any segment still open at the end of this frame.
		if (eod_s1) begin
			if (active_n && !emit) begin
				emit       = 1'b1;
				emit_final = 1'b1;
				emit_len   = seg_len_n;
			end
			active_n    = 1'b0;
			quiet_cnt_n = 16'd0;
		end
	end

	// Segment state update; frames after end of data leave it untouched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= 8'd0;
			active_q    <= 1'b0;
			quiet_cnt_q <= 16'd0;
			pos_q       <= '0;
			begin_q     <= '0;
			seg_len_q   <= '0;
			finished_q  <= 1'b0;
		end else if (advance && !finished_q) begin
			prev_q      <= sample_s1;
			active_q    <= active_n;
			quiet_cnt_q <= quiet_cnt_n;
			pos_q       <= pos_next;
			begin_q     <= begin_n;
			seg_len_q   <= seg_len_n;
			finished_q  <= eod_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit && !finished_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			start_q  <= OUT_W'(begin_n);
			length_q <= OUT_W'(emit_len);
			kept_q   <= CMP_W'(emit_len) >= CMP_W'(cfg.min_length);
			final_q  <= emit_final;
		end
	end

	assign out_valid      = out_valid_q;
	assign segment_start  = start_q;
	assign segment_length = length_q;
	assign segment_kept   = kept_q;
	assign final_segment  = final_q;

	// Nothing new is reported once end of data has been processed.
	a_no_result_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q && advance |=> !out_valid_q)
		else $error("result produced after end of data");

	// A segment reported as closed by end of data implies the finished state.
	a_final_implies_finished: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && final_q |-> finished_q)
		else $error("final segment reported without end of data");

	// The quiet counter only runs inside an open segment.
	a_quiet_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> quiet_cnt_q == 16'd0)
		else $error("quiet counter nonzero while seeking");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for silence_gap_segmenter_top: frame stimulus, result checking.
// Depends on sgs_pkg and the segmenter RTL; it predicts each segment with its own tracker.
`timescale 1ns / 1ps

module tb_top;
	import sgs_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 6;
	localparam int REPORT_LIMIT = 10;

	// One frame transaction as queued for the driver.
	typedef struct packed {
		logic [7:0] smp;
		logic       eod;
	} frame_t;

	// One segment transaction as reported by the block.
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
		logic        kept;
		logic        closed_by_end;
	} segment_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        sample_byte = 8'd0;
	logic              end_of_data = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [OUT_W-1:0]  segment_start;
	logic [OUT_W-1:0]  segment_length;
	logic              segment_kept;
	logic              final_segment;

	silence_gap_segmenter_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_byte    (sample_byte),
		.end_of_data    (end_of_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.segment_start  (segment_start),
		.segment_length (segment_length),
		.segment_kept   (segment_kept),
		.final_segment  (final_segment)
	);

	// Frames waiting for the driver and segments waiting for the block.
	frame_t   frame_queue[$];
	segment_t segment_expect_q[$];

	int send_idle_pct = 19;
	int recv_idle_pct = 74;
	int hold_order = 0;
	int hold_left = 0;
	int mismatch_count = 0;
	int stall_cycles = 0;

	// Configuration as the tracker sees it, starting from the reset values.
	logic [7:0]  cfg_sensitivity = SENSITIVITY_RST;
	logic [15:0] cfg_silence_run = SILENCE_RUN_RST;
	logic [31:0] cfg_min_length = MIN_LENGTH_RST;
	logic [3:0]  cfg_bytes_per_frame = BYTES_PER_FRAME_RST;

	// Segment tracker state.
	logic [7:0]  prev_sample = 8'd0;
	logic        seg_active = 1'b0;
	logic [15:0] quiet_run = 16'd0;
	logic [31:0] byte_pos = 32'd0;
	logic [31:0] seg_begin = 32'd0;
	logic        stream_done = 1'b0;

	// Last byte handed to the frame queue, used to shape quiet and loud frames.
	logic [7:0]  gen_last = 8'd0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void note_mismatch(input string detail);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch: %s", detail);
	endfunction

	// Record the expected segment that ends at byte offset end_pos.
	function automatic void close_segment(input logic [31:0] end_pos, input logic by_end);
		segment_t seg;
		seg.start = seg_begin;
		seg.length = end_pos - seg_begin;
		seg.kept = (seg.length >= cfg_min_length);
		seg.closed_by_end = by_end;
		segment_expect_q.push_back(seg);
	endfunction

	// Advance the segment tracker by one accepted frame.
	function automatic void track_frame(input logic [7:0] smp, input logic eod);
		logic [7:0]  diff;
		logic        quiet;
		logic        closed;
		logic [31:0] frame_pos;
		logic [31:0] run_bytes;
		logic [15:0] run_len;
		logic [3:0]  bpf;
		if (stream_done)
			return;
		bpf = (cfg_bytes_per_frame == 4'd0) ? 4'd1 : cfg_bytes_per_frame;
		run_len = (cfg_silence_run == 16'd0) ? 16'd1 : cfg_silence_run;
		diff = (smp > prev_sample) ? smp - prev_sample : prev_sample - smp;
		quiet = (diff < cfg_sensitivity);
		prev_sample = smp;
		frame_pos = byte_pos;
		byte_pos = byte_pos + 32'(bpf);
		closed = 1'b0;
		if (!seg_active) begin
			if (!quiet) begin
				seg_active = 1'b1;
				seg_begin = frame_pos;
				quiet_run = 16'd0;
			end
		end else begin
			if (!quiet)
				quiet_run = 16'd0;
			else if (quiet_run != 16'hFFFF)
				quiet_run++;
			// A full silence run closes the segment, its end set back by that run.
			if (quiet_run >= run_len) begin
				run_bytes = 32'(run_len) * 32'(bpf);
				close_segment(byte_pos - run_bytes, 1'b0);
				closed = 1'b1;
				seg_active = 1'b0;
				quiet_run = 16'd0;
			end
		end
		if (eod) begin
			stream_done = 1'b1;
			if (seg_active && !closed)
				close_segment(byte_pos, 1'b1);
			seg_active = 1'b0;
			quiet_run = 16'd0;
		end
	endfunction

	function automatic void queue_frame(input logic [7:0] smp, input logic eod);
		frame_queue.push_back('{smp: smp, eod: eod});
		gen_last = smp;
	endfunction

	// A byte whose distance from the last queued byte is below the sensitivity; the last byte itself at zero sensitivity.
	function automatic logic [7:0] quiet_byte();
		int lo;
		int hi;
		if (cfg_sensitivity == 8'd0)
			return gen_last;
		lo = int'(gen_last) - int'(cfg_sensitivity) + 1;
		hi = int'(gen_last) + int'(cfg_sensitivity) - 1;
		if (lo < 0)
			lo = 0;
		if (hi > 255)
			hi = 255;
		return 8'($urandom_range(hi, lo));
	endfunction

	// A byte at least the sensitivity away from the last queued byte, where one exists.
	function automatic logic [7:0] loud_byte();
		int  s;
		int  last;
		logic dn;
		logic up;
		s = int'(cfg_sensitivity);
		last = int'(gen_last);
		dn = (last >= s);
		up = (last + s <= 255);
		if (dn && (!up || $urandom_range(1, 0) == 1))
			return 8'($urandom_range(last - s, 0));
		if (up)
			return 8'($urandom_range(255, last + s));
		return (last < 128) ? 8'd255 : 8'd0;
	endfunction

	// Mostly well-formed segments (loud body, short dips, closing silence), some noise.
	function automatic void queue_segments(input int count);
		int run_len;
		int dip_max;
		int quiet_len;
		run_len = (cfg_silence_run == 16'd0) ? 1 : int'(cfg_silence_run);
		dip_max = (run_len - 1 < 6) ? run_len - 1 : 6;
		while (count > 0) begin
			if ($urandom_range(99, 0) < 15) begin
				queue_frame(8'($urandom), 1'b0);
				count--;
			end else begin
				repeat ($urandom_range(4, 1)) begin
					queue_frame(loud_byte(), 1'b0);
					count--;
					if ($urandom_range(2, 0) == 0)
						repeat ($urandom_range(dip_max, 0)) begin
							queue_frame(quiet_byte(), 1'b0);
							count--;
						end
				end
				// Usually a closing run, now and then one frame short of it.
				quiet_len = run_len + int'($urandom_range(3, 0));
				if ($urandom_range(7, 0) == 0)
					quiet_len = run_len - 1;
				if (quiet_len > 40)
					quiet_len = 40;
				repeat (quiet_len) begin
					queue_frame(quiet_byte(), 1'b0);
					count--;
				end
			end
		end
	endfunction

	// Write one register, then read it back.
	task automatic write_reg(input sgs_reg_t idx, input logic [31:0] value);
		logic [31:0] stored;
		case (idx)
			REG_SENSITIVITY: begin
				cfg_sensitivity = value[7:0];
				stored = {24'd0, value[7:0]};
			end
			REG_SILENCE_RUN: begin
				cfg_silence_run = value[15:0];
				stored = {16'd0, value[15:0]};
			end
			REG_MIN_LENGTH: begin
				cfg_min_length = value;
				stored = value;
			end
			default: begin
				cfg_bytes_per_frame = value[3:0];
				stored = {28'd0, value[3:0]};
			end
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= stored;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (prdata !== stored)
			note_mismatch($sformatf("register %s read %0h, expected %0h",
				idx.name(), prdata, stored));
	endtask

	task automatic configure(input logic [7:0] sens, input logic [15:0] run_len,
			input logic [31:0] min_len, input logic [3:0] bpf);
		write_reg(REG_SENSITIVITY, {24'd0, sens});
		write_reg(REG_SILENCE_RUN, {16'd0, run_len});
		write_reg(REG_MIN_LENGTH, min_len);
		write_reg(REG_BYTES_PER_FRAME, {28'd0, bpf});
	endtask

	// Wait until every frame is taken and every segment is back, then let the pipeline empty.
	task automatic drain();
		do
			@(negedge clk);
		while (frame_queue.size() != 0 || in_valid || segment_expect_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Driver: presents queued frames, tracks each accepted transaction.
	always @(posedge clk) begin
		frame_t next_frame;
		if (arst_n) begin
			if (in_valid && in_ready)
				track_frame(sample_byte, end_of_data);
			if (!in_valid || in_ready) begin
				if (frame_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					next_frame = frame_queue.pop_front();
					in_valid <= 1'b1;
					sample_byte <= next_frame.smp;
					end_of_data <= next_frame.eod;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each segment transaction and drives out_ready, with long hold-offs.
	always @(posedge clk) begin
		segment_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (segment_expect_q.size() == 0) begin
					note_mismatch($sformatf("unexpected segment start=%0d length=%0d kept=%0b final=%0b",
						segment_start, segment_length, segment_kept, final_segment));
				end else begin
					want = segment_expect_q.pop_front();
					if (segment_start !== want.start || segment_length !== want.length ||
							segment_kept !== want.kept || final_segment !== want.closed_by_end)
						note_mismatch($sformatf(
							"segment expected start=%0d length=%0d kept=%0b final=%0b, got %0d %0d %0b %0b",
							want.start, want.length, want.kept, want.closed_by_end,
							segment_start, segment_length, segment_kept, final_segment));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_order > 0) begin
				hold_left = hold_order;
				hold_order = 0;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Stimulus sequence.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: quiet, loud, quiet and loud frames at the byte extremes.
		queue_frame(8'd0, 1'b0);
		queue_frame(8'd255, 1'b0);
		queue_frame(8'd254, 1'b0);
		queue_frame(8'd0, 1'b0);
		drain();

		// Zero silence run and zero frame size, widest sensitivity.
		configure(8'd255, 16'd0, 32'd0, 4'd0);
		queue_frame(8'd255, 1'b0);
		queue_frame(8'd255, 1'b0);
		queue_frame(8'd0, 1'b0);
		queue_frame(8'd0, 1'b0);
		drain();

		// No frame can be quiet; largest minimum length and a nine-byte frame.
		configure(8'd0, 16'd1, 32'hFFFF_FFFF, 4'd9);
		queue_frame(8'd0, 1'b0);
		queue_frame(8'd128, 1'b0);
		queue_frame(8'd255, 1'b0);
		queue_frame(8'd255, 1'b0);
		drain();

		// Close the segment left open, then a short segment against a minimum length it misses.
		configure(8'd2, 16'd2, 32'd20, 4'd8);
		queue_frame(8'd254, 1'b0);
		queue_frame(8'd255, 1'b0);
		queue_frame(8'd0, 1'b0);
		queue_frame(8'd1, 1'b0);
		queue_frame(8'd0, 1'b0);
		drain();

		// Random phases under changing settings and idling patterns.
		for (int ph = 0; ph < 10; ph++) begin
			send_idle_pct = (ph < 3) ? 19 : (ph < 6) ? 74 : 0;
			recv_idle_pct = (ph < 3) ? 74 : (ph < 6) ? 19 : 0;
			case (ph)
				1: configure(8'd255, 16'd65535, 32'hFFFF_FFFF, 4'd15);
				6: configure(8'd40, 16'd1, 32'd6, 4'd4);
				default: configure(8'($urandom_range(64, 1)), 16'($urandom_range(12, 0)),
					($urandom_range(3, 0) == 0) ? 32'($urandom) : 32'($urandom_range(60, 0)),
					4'($urandom_range(15, 0)));
			endcase
			queue_segments(130);
			// Long receiver hold-off while frames keep coming.
			if (ph == 6)
				hold_order = 120;
			drain();
		end

		// Closing sequence: first return to seeking, then end the data one of three ways.
		configure(8'd30, 16'd2, 32'd4, 4'd3);
		queue_frame(loud_byte(), 1'b0);
		queue_frame(quiet_byte(), 1'b0);
		queue_frame(quiet_byte(), 1'b0);
		case ($urandom_range(2, 0))
			0: begin
				// Open segment closed by the end of data.
				queue_frame(loud_byte(), 1'b0);
				queue_frame(loud_byte(), 1'b0);
				queue_frame(loud_byte(), 1'b1);
			end
			1: begin
				// Silence run completes on the last frame.
				queue_frame(loud_byte(), 1'b0);
				queue_frame(quiet_byte(), 1'b0);
				queue_frame(quiet_byte(), 1'b1);
			end
			default: begin
				// Segment opens on the last frame.
				queue_frame(quiet_byte(), 1'b0);
				queue_frame(loud_byte(), 1'b1);
			end
		endcase
		// Frames after the end of data must be dropped.
		repeat (5) queue_frame(8'($urandom), 1'($urandom));
		drain();

		if (mismatch_count == 0 && segment_expect_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ files.f @@
rtl/sgs_pkg.sv
rtl/sgs_regs.sv
rtl/silence_gap_segmenter_top.sv
verif/tb_top.sv
